[rtl/core/vfla_pkg.sv]
package vfla_pkg;

  // request codes
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_CLAIM   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_BAD     = 2'd3
  } op_t;

  // result status codes
  localparam logic [1:0] RES_GRANTED  = 2'd0;
  localparam logic [1:0] RES_REFUSED  = 2'd1;
  localparam logic [1:0] RES_RELEASED = 2'd2;
  localparam logic [1:0] RES_IGNORED  = 2'd3;

  // per-identifier status marks
  localparam logic [1:0] ENT_NEW  = 2'd0;
  localparam logic [1:0] ENT_FREE = 2'd1;
  localparam logic [1:0] ENT_USED = 2'd2;

  // refill counter saturates here
  localparam int              REFILL_CNT_W = 7;
  localparam logic [6:0]      REFILL_MAX   = 7'd127;

  // register file
  localparam int          APB_AW       = 3;
  localparam int          REG_IDX_BIT  = 2;
  localparam logic        REG_MIN_VCI  = 1'b0;
  localparam logic        REG_MIN_SIZE = 1'b1;
  localparam int          MIN_VCI_RST  = 31;
  localparam int          MIN_SIZE_RST = 16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REFILL,
    ST_ALLOC_CHK,
    ST_READ,
    ST_EVAL,
    ST_RESULT
  } state_t;

endpackage

[rtl/core/vci_free_list_allocator.sv]
// Channel identifier allocator with an ordered free list.
// Request channel (in_valid/in_ready, opcode, vci): allocate any identifier,
// claim a given one, or release one. Each request transaction produces exactly
// one result transaction (out_valid/out_ready, vci_out, status).
// Claim and release step through read, evaluate and result states; an
// allocate checks the free count first and, when it is below min_size,
// appends a fresh block of never-issued identifiers before that read
// (fewer when the block runs into the top identifier).
// One request is worked on at a time, set by the read-modify-write over
// the status and link memories (one read, then one write per memory).
// Reset: a clearing pass writes every status mark to "never issued", one
// entry per cycle; no request is taken until it ends.
// Configuration writes over the APB port are taken at any time.
// Stall: a finished result waits in the output register; the next request is
// still accepted and worked on, and holds in its final state until the
// output register is free.
module vci_free_list_allocator #(
  parameter int VCI_BITS    = 12,
  parameter int REFILL_SIZE = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vfla_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  opcode,
  input  logic [VCI_BITS-1:0]         vci,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [VCI_BITS-1:0]         vci_out,
  output logic [1:0]                  status
);

  import vfla_pkg::*;

  logic [VCI_BITS-1:0] min_vci;
  logic [VCI_BITS:0]   min_size;
  logic                res_valid;
  logic                res_ready;
  logic [VCI_BITS-1:0] res_vci;
  logic [1:0]          res_status;

  vfla_apb_regs #(.VCI_BITS(VCI_BITS)) u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .min_vci  (min_vci),
    .min_size (min_size)
  );

  vfla_seq #(.VCI_BITS(VCI_BITS), .REFILL_SIZE(REFILL_SIZE)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .min_vci    (min_vci),
    .min_size   (min_size),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .vci        (vci),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_vci    (res_vci),
    .res_status (res_status)
  );

  // output register: free, or being emptied this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      vci_out <= res_vci;
      status  <= res_status;
    end
  end

endmodule

[rtl/core/vfla_ram.sv]
module vfla_ram #(
  parameter int WIDTH = 12,
  parameter int ABITS = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [ABITS-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**ABITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/vfla_apb_regs.sv]
module vfla_apb_regs #(
  parameter int VCI_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vfla_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [VCI_BITS-1:0]         min_vci,
  output logic [VCI_BITS:0]           min_size
);

  import vfla_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_vci  <= VCI_BITS'(MIN_VCI_RST);
      min_size <= (VCI_BITS+1)'(MIN_SIZE_RST);
    end else if (wr) begin
      if (paddr[REG_IDX_BIT] == REG_MIN_SIZE) begin
        min_size <= pwdata[VCI_BITS:0];
      end else begin
        min_vci <= pwdata[VCI_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[REG_IDX_BIT] == REG_MIN_SIZE) begin
      prdata = 32'(min_size);
    end else begin
      prdata = 32'(min_vci);
    end
  end

endmodule

[rtl/core/vfla_seq.sv]
module vfla_seq #(
  parameter int VCI_BITS    = 12,
  parameter int REFILL_SIZE = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [VCI_BITS-1:0] min_vci,
  input  logic [VCI_BITS:0]   min_size,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          opcode,
  input  logic [VCI_BITS-1:0] vci,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [VCI_BITS-1:0] res_vci,
  output logic [1:0]          res_status
);

  import vfla_pkg::*;

  localparam int BASE_W = ((VCI_BITS > 15) ? VCI_BITS : 15) + 1;
  localparam int SCNT_W = $clog2(REFILL_SIZE + 1);

  state_t                   state, state_next;
  op_t                      op, op_next;
  logic [VCI_BITS-1:0]      cur_v, cur_v_next;
  logic [VCI_BITS-1:0]      head, head_next;
  logic [VCI_BITS-1:0]      tail, tail_next;
  logic [VCI_BITS:0]        count, count_next;
  logic [REFILL_CNT_W-1:0]  refills, refills_next;
  logic [BASE_W-1:0]        scan_v, scan_v_next;
  logic [SCNT_W-1:0]        scan_cnt, scan_cnt_next;
  logic                     refill_ok, refill_ok_next;
  logic                     pend, pend_next;
  logic [VCI_BITS-1:0]      pend_v, pend_v_next;
  logic [VCI_BITS-1:0]      clr_addr, clr_addr_next;
  logic [VCI_BITS-1:0]      res_vci_next;
  logic [1:0]               res_status_next;

  logic [BASE_W-1:0]        base;
  logic                     base_ok;
  logic                     scan_go;

  // memory ports
  logic                s_we, n_we, p_we;
  logic [VCI_BITS-1:0] s_waddr, n_waddr, p_waddr, s_raddr;
  logic [1:0]          s_wdata, s_rdata;
  logic [VCI_BITS-1:0] n_wdata, p_wdata, n_rdata, p_rdata;

  vfla_ram #(.WIDTH(2), .ABITS(VCI_BITS)) u_status (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  vfla_ram #(.WIDTH(VCI_BITS), .ABITS(VCI_BITS)) u_next (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(cur_v), .rdata(n_rdata)
  );

  vfla_ram #(.WIDTH(VCI_BITS), .ABITS(VCI_BITS)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(cur_v), .rdata(p_rdata)
  );

  assign base    = BASE_W'(min_vci) + BASE_W'(1)
                 + BASE_W'(refills) * BASE_W'(REFILL_SIZE);
  assign base_ok = (base[BASE_W-1:VCI_BITS] == '0);
  assign scan_go = (scan_cnt != SCNT_W'(REFILL_SIZE))
                && (scan_v[BASE_W-1:VCI_BITS] == '0);
  assign s_raddr = (state == ST_REFILL) ? scan_v[VCI_BITS-1:0] : cur_v;

  assign res_valid = (state == ST_RESULT);
  assign in_ready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      refills  <= '0;
      pend     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      head     <= head_next;
      tail     <= tail_next;
      count    <= count_next;
      refills  <= refills_next;
      pend     <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    cur_v      <= cur_v_next;
    scan_v     <= scan_v_next;
    scan_cnt   <= scan_cnt_next;
    refill_ok  <= refill_ok_next;
    pend_v     <= pend_v_next;
    res_vci    <= res_vci_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    cur_v_next      = cur_v;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    refills_next    = refills;
    scan_v_next     = scan_v;
    scan_cnt_next   = scan_cnt;
    refill_ok_next  = refill_ok;
    pend_next       = pend;
    pend_v_next     = pend_v;
    clr_addr_next   = clr_addr;
    res_vci_next    = res_vci;
    res_status_next = res_status;
    s_we    = 1'b0;
    s_waddr = cur_v;
    s_wdata = ENT_NEW;
    n_we    = 1'b0;
    n_waddr = tail;
    n_wdata = cur_v;
    p_we    = 1'b0;
    p_waddr = cur_v;
    p_wdata = tail;

    unique case (state)
      ST_CLEAR: begin
        s_we          = 1'b1;
        s_waddr       = clr_addr;
        s_wdata       = ENT_NEW;
        clr_addr_next = clr_addr + 1'b1;
        if (&clr_addr) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_next    = op_t'(opcode);
          cur_v_next = vci;
          unique case (op_t'(opcode))
            OP_ALLOC: begin
              if (count < min_size) begin
                scan_v_next    = base;
                scan_cnt_next  = '0;
                refill_ok_next = base_ok;
                pend_next      = 1'b0;
                state_next     = ST_REFILL;
              end else begin
                state_next = ST_ALLOC_CHK;
              end
            end
            OP_CLAIM, OP_RELEASE: begin
              state_next = ST_READ;
            end
            OP_BAD: begin
              res_vci_next    = '0;
              res_status_next = RES_REFUSED;
              state_next      = ST_RESULT;
            end
          endcase
        end
      end

      ST_REFILL: begin
        // status of the previous scan slot is back: append it if never issued
        if (pend && s_rdata == ENT_NEW) begin
          s_we    = 1'b1;
          s_waddr = pend_v;
          s_wdata = ENT_FREE;
          if (count != '0) begin
            n_we    = 1'b1;
            n_waddr = tail;
            n_wdata = pend_v;
            p_we    = 1'b1;
            p_waddr = pend_v;
            p_wdata = tail;
          end else begin
            head_next = pend_v;
          end
          tail_next  = pend_v;
          count_next = count + 1'b1;
        end
        pend_next   = scan_go;
        pend_v_next = scan_v[VCI_BITS-1:0];
        if (scan_go) begin
          scan_v_next   = scan_v + 1'b1;
          scan_cnt_next = scan_cnt + 1'b1;
        end
        if (!scan_go && !pend) begin
          if (refill_ok && refills != REFILL_MAX) begin
            refills_next = refills + 1'b1;
          end
          state_next = ST_ALLOC_CHK;
        end
      end

      ST_ALLOC_CHK: begin
        if (count != '0) begin
          cur_v_next = head;
          state_next = ST_READ;
        end else begin
          res_vci_next    = '0;
          res_status_next = RES_REFUSED;
          state_next      = ST_RESULT;
        end
      end

      ST_READ: begin
        state_next = ST_EVAL;
      end

      ST_EVAL: begin
        state_next      = ST_RESULT;
        res_vci_next    = '0;
        res_status_next = RES_REFUSED;
        unique case (op)
          OP_ALLOC, OP_CLAIM: begin
            if (op == OP_ALLOC || s_rdata == ENT_FREE) begin
              // unlink cur_v; prev/next links came back from the read
              if (cur_v == head) begin
                head_next = n_rdata;
              end else begin
                n_we    = 1'b1;
                n_waddr = p_rdata;
                n_wdata = n_rdata;
              end
              if (cur_v == tail) begin
                tail_next = p_rdata;
              end else begin
                p_we    = 1'b1;
                p_waddr = n_rdata;
                p_wdata = p_rdata;
              end
              count_next      = count - 1'b1;
              s_we            = 1'b1;
              s_waddr         = cur_v;
              s_wdata         = ENT_USED;
              res_vci_next    = cur_v;
              res_status_next = RES_GRANTED;
            end
          end
          OP_RELEASE: begin
            if (s_rdata == ENT_USED) begin
              if (count != '0) begin
                n_we    = 1'b1;
                n_waddr = tail;
                n_wdata = cur_v;
                p_we    = 1'b1;
                p_waddr = cur_v;
                p_wdata = tail;
              end else begin
                head_next = cur_v;
              end
              tail_next       = cur_v;
              count_next      = count + 1'b1;
              s_we            = 1'b1;
              s_waddr         = cur_v;
              s_wdata         = ENT_FREE;
              res_status_next = RES_RELEASED;
            end else begin
              res_status_next = RES_IGNORED;
            end
          end
          OP_BAD: begin
            res_status_next = RES_REFUSED;
          end
        endcase
      end

      ST_RESULT: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[dv/tb_vci_free_list_allocator.sv]
module tb_vci_free_list_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import vfla_pkg::*;

  localparam int ID_W           = 12;
  localparam int BLOCK          = 64;
  localparam int TOP_ID         = (1 << ID_W) - 1;
  // limit outlasts the clearing pass and a refill, both with no port activity
  localparam int WATCHDOG_LIMIT = 20000;

  localparam logic [APB_AW-1:0] ADDR_MIN_VCI  = APB_AW'(int'(REG_MIN_VCI) << REG_IDX_BIT);
  localparam logic [APB_AW-1:0] ADDR_MIN_SIZE = APB_AW'(int'(REG_MIN_SIZE) << REG_IDX_BIT);

  typedef struct packed {
    logic [ID_W-1:0] vci;
    logic [1:0]      st;
  } grant_t;

  // ---------------------------------------------------------------------------
  // DUT ports; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        opcode   = OP_ALLOC;
  logic [ID_W-1:0]   vci      = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ID_W-1:0]   vci_out;
  logic [1:0]        status;

  vci_free_list_allocator #(
    .VCI_BITS    (ID_W),
    .REFILL_SIZE (BLOCK)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .vci       (vci),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .vci_out   (vci_out),
    .status    (status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the allocator: status marks, list links, head/tail, counters
  // ---------------------------------------------------------------------------
  logic [1:0]      mark [TOP_ID+1];
  logic [ID_W-1:0] nxt  [TOP_ID+1];
  logic [ID_W-1:0] prv  [TOP_ID+1];
  logic [ID_W-1:0] head, tail;
  logic [12:0]     nfree;
  logic [6:0]      nrefill;
  logic [ID_W-1:0] cfg_min_vci;
  logic [12:0]     cfg_min_size;

  grant_t grants_due[$];   // results owed by the DUT, oldest first
  int     errors      = 0;
  bit     steady_flow = 1'b0; // no idling on either side while set

  // append to the tail of the free list
  function automatic void push_free(input logic [ID_W-1:0] v);
    if (nfree == 0) begin
      head = v;
    end else begin
      nxt[tail] = v;
      prv[v]    = tail;
    end
    tail    = v;
    mark[v] = ENT_FREE;
    nfree++;
  endfunction

  // unlink from anywhere in the list and mark in use
  function automatic void take_entry(input logic [ID_W-1:0] v);
    logic [ID_W-1:0] p, n;
    p = prv[v];
    n = nxt[v];
    if (v == head) head = n;
    else           nxt[p] = n;
    if (v == tail) tail = p;
    else           prv[n] = p;
    nfree--;
    mark[v] = ENT_USED;
  endfunction

  // fresh block of never-issued ids; stops at the top id, skips ids seen before
  function automatic void top_up();
    int base;
    base = int'(cfg_min_vci) + 1 + int'(nrefill) * BLOCK;
    if (base > TOP_ID) return;
    for (int i = 0; i < BLOCK; i++) begin
      if (base + i > TOP_ID) break;
      if (mark[ID_W'(base + i)] == ENT_NEW) push_free(ID_W'(base + i));
    end
    if (nrefill < REFILL_MAX) nrefill++;
  endfunction

  function automatic grant_t predict(input op_t op, input logic [ID_W-1:0] id);
    grant_t r;
    r.vci = '0;
    r.st  = RES_REFUSED;
    case (op)
      OP_ALLOC: begin
        if (nfree < cfg_min_size) top_up();
        if (nfree != 0) begin
          r.vci = head;
          r.st  = RES_GRANTED;
          take_entry(head);
        end
      end
      OP_CLAIM: begin
        if (mark[id] == ENT_FREE) begin
          take_entry(id);
          r.vci = id;
          r.st  = RES_GRANTED;
        end
      end
      OP_RELEASE: begin
        if (mark[id] == ENT_USED) begin
          push_free(id);
          r.st = RES_RELEASED;
        end else begin
          r.st = RES_IGNORED;
        end
      end
      default: ; // unused code: refused, no change
    endcase
    return r;
  endfunction

  // random id carrying the given mark, -1 if none
  function automatic int find_marked(input logic [1:0] m);
    int start;
    start = $urandom_range(0, TOP_ID);
    for (int i = 0; i <= TOP_ID; i++) begin
      if (mark[ID_W'((start + i) % (TOP_ID + 1))] == m) return (start + i) % (TOP_ID + 1);
    end
    return -1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: one transaction per call, valid held until accepted
  // ---------------------------------------------------------------------------
  task automatic send_req(input op_t op, input logic [ID_W-1:0] id);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    vci      <= id;
    do @(posedge clk); while (!in_ready);
    grants_due.push_back(predict(op, id));
  endtask

  // drop valid and wait for every owed result; the clock is always awaited before the check
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (grants_due.size() != 0);
  endtask

  task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
                          input logic [31:0] data, output logic [31:0] rd);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);  // access phase completes here, pready tied high
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // registers only change with the block idle
  task automatic set_limits(input int mv, input int ms);
    logic [31:0] rd;
    drain_results();
    repeat (6) @(posedge clk);
    apb_xfer(1'b1, ADDR_MIN_VCI, 32'(mv), rd);
    apb_xfer(1'b1, ADDR_MIN_SIZE, 32'(ms), rd);
    cfg_min_vci  = ID_W'(mv);
    cfg_min_size = 13'(ms);
    apb_xfer(1'b0, ADDR_MIN_VCI, '0, rd);
    if (rd[ID_W-1:0] !== cfg_min_vci) begin
      $error("min_vci readback: expected %0d, got %0d", cfg_min_vci, rd[ID_W-1:0]);
      errors++;
    end
    apb_xfer(1'b0, ADDR_MIN_SIZE, '0, rd);
    if (rd[12:0] !== cfg_min_size) begin
      $error("min_size readback: expected %0d, got %0d", cfg_min_size, rd[12:0]);
      errors++;
    end
  endtask

  // mostly legal traffic steered by the shadow, plus refused/ignored noise
  task automatic random_request();
    int pick;
    int id;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_req(OP_ALLOC, ID_W'($urandom_range(0, TOP_ID)));
    end else if (pick < 60) begin
      id = find_marked(ENT_USED);
      if (id < 0) send_req(OP_ALLOC, '0);
      else        send_req(OP_RELEASE, ID_W'(id));
    end else if (pick < 72) begin
      id = find_marked(ENT_FREE);
      if (id < 0) send_req(OP_ALLOC, '0);
      else        send_req(OP_CLAIM, ID_W'(id));
    end else if (pick < 82) begin
      send_req(OP_CLAIM, ID_W'($urandom_range(0, TOP_ID)));
    end else if (pick < 92) begin
      send_req(OP_RELEASE, ID_W'($urandom_range(0, TOP_ID)));
    end else if (pick < 96) begin
      id = find_marked(ENT_FREE);  // double release of a free id
      send_req(OP_RELEASE, ID_W'((id < 0) ? 0 : id));
    end else begin
      send_req(OP_BAD, ID_W'($urandom_range(0, TOP_ID)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test cases
  // ---------------------------------------------------------------------------

  // min_vci one below the top id, min_size 4096: a one-id refill truncated at the top id,
  // then a refill lying wholly above it
  task automatic test_register_extremes();
    set_limits(TOP_ID - 1, 4096);
    send_req(OP_ALLOC, ID_W'(TOP_ID));   // vci field ignored on allocate
    send_req(OP_ALLOC, '0);              // empty after refill
    send_req(OP_CLAIM, ID_W'(TOP_ID));   // in use: refused
    send_req(OP_RELEASE, ID_W'(TOP_ID));
    send_req(OP_RELEASE, ID_W'(TOP_ID)); // already free: ignored
    send_req(OP_CLAIM, ID_W'(TOP_ID));   // sole list entry
    send_req(OP_RELEASE, '0);            // never issued: ignored
    send_req(OP_BAD, ID_W'(TOP_ID));
    send_req(OP_RELEASE, ID_W'(TOP_ID));
  endtask

  // zero threshold never refills
  task automatic test_no_refill();
    set_limits(0, 0);
    send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '0);
    send_req(OP_CLAIM, '0);
    send_req(OP_RELEASE, ID_W'(TOP_ID));
  endtask

  // reset values; unlink at head, middle and tail, tail re-append
  task automatic test_list_operations();
    set_limits(MIN_VCI_RST, MIN_SIZE_RST);
    send_req(OP_ALLOC, '0);          // refill then pop
    send_req(OP_CLAIM, 12'd120);
    send_req(OP_CLAIM, 12'd96);
    send_req(OP_CLAIM, 12'd159);
    send_req(OP_CLAIM, 12'd159);
    send_req(OP_RELEASE, 12'd120);
    send_req(OP_RELEASE, 12'd120);
    send_req(OP_CLAIM, 12'd120);
    send_req(OP_RELEASE, 12'd96);
    send_req(OP_ALLOC, '1);
    send_req(OP_CLAIM, 12'd50);
    send_req(OP_BAD, '0);
    send_req(OP_RELEASE, ID_W'(TOP_ID));
  endtask

  // pauses for every owed result halfway through
  task automatic test_random_traffic(input int n, input bit steady);
    steady_flow = steady;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain_results();
      random_request();
    end
    steady_flow = 1'b0;
  endtask

  // every allocate refills until the fresh blocks run past the top id
  task automatic test_exhaustion();
    set_limits(0, 4096);
    test_random_traffic(100, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, one draw per transaction
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // each result transaction against the oldest owed one
  always @(posedge clk) begin
    grant_t due;
    if (!rst && out_valid && out_ready) begin
      if (grants_due.size() == 0) begin
        $error("status: result with nothing owed, vci_out %0d status %0d", vci_out, status);
        errors++;
      end else begin
        due = grants_due.pop_front();
        if (vci_out !== due.vci) begin
          $error("vci_out: expected %0d, got %0d", due.vci, vci_out);
          errors++;
        end
        if (status !== due.st) begin
          $error("status: expected %0d, got %0d", due.st, status);
          errors++;
        end
      end
    end
  end

  // stall guard: cycles with no transaction on any port
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[vci_free_list_allocator] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (mark[i]) begin
      mark[i] = ENT_NEW;
      nxt[i]  = '0;
      prv[i]  = '0;
    end
    head         = '0;
    tail         = '0;
    nfree        = '0;
    nrefill      = '0;
    cfg_min_vci  = ID_W'(MIN_VCI_RST);
    cfg_min_size = 13'(MIN_SIZE_RST);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_register_extremes();
    test_no_refill();
    test_list_operations();
    set_limits(MIN_VCI_RST, MIN_SIZE_RST);
    test_random_traffic(250, 1'b0);
    set_limits(0, 1);                 // lowered base overlaps issued ids
    test_random_traffic(200, 1'b1);
    set_limits(2000, 200);
    test_random_traffic(250, 1'b0);
    test_exhaustion();

    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0 && grants_due.size() == 0) begin
      $display("[vci_free_list_allocator] OK");
    end else begin
      $display("[vci_free_list_allocator] ERROR");
    end
    $finish;
  end

endmodule

[vci_free_list_allocator.f]
rtl/core/vfla_pkg.sv
rtl/core/vfla_ram.sv
rtl/core/vfla_apb_regs.sv
rtl/core/vfla_seq.sv
rtl/core/vci_free_list_allocator.sv
dv/tb_vci_free_list_allocator.sv
